// ===== hdl/srle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srle_pkg
// Types, constants and the per-nibble decode step of the subpicture
// run-length field decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 10;

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CfgLeftEdge   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CfgRightEdge  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CfgTopEdge    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CfgBottomEdge = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CfgFieldSel   = 3'd4;

  localparam logic [9:0] LeftEdgeReset   = 10'd0;
  localparam logic [9:0] RightEdgeReset  = 10'd719;
  localparam logic [9:0] TopEdgeReset    = 10'd0;
  localparam logic [9:0] BottomEdgeReset = 10'd575;

  // a code continues while its value stays below these after 1, 2, 3 nibbles
  localparam logic [15:0] Code1Limit = 16'h0004;
  localparam logic [15:0] Code2Limit = 16'h0010;
  localparam logic [15:0] Code3Limit = 16'h0040;
  localparam logic [1:0]  ColourMask = 2'h3;

  localparam logic [13:0] LenMax     = 14'd1023;

  typedef struct packed {
    logic [9:0] run_x;
    logic [9:0] run_y;
    logic [9:0] run_length;
    logic [1:0] run_colour;
    logic       line_end;
    logic       field_done;
    logic       last_of_byte;
  } run_t;

  typedef struct packed {
    logic [11:0] partial;
    logic [1:0]  held;
    logic [10:0] col;
    logic [9:0]  line;
  } dec_state_t;

  typedef struct packed {
    logic       emit;
    run_t       run;
    dec_state_t nxt;
  } step_t;

  function automatic step_t nibble_step(dec_state_t s, logic [3:0] nib,
                                        logic [9:0] le, logic [9:0] re,
                                        logic [9:0] be);
    step_t       r;
    logic [2:0]  held_n;
    logic [15:0] vlc;
    logic        done;
    logic [13:0] len;
    logic [10:0] col_sum;
    logic [10:0] ny;
    r       = '0;
    r.nxt   = s;
    held_n  = {1'b0, s.held} + 3'd1;
    vlc     = {s.partial, nib};
    case (held_n)
      3'd1:    done = (vlc >= Code1Limit);
      3'd2:    done = (vlc >= Code2Limit);
      3'd3:    done = (vlc >= Code3Limit);
      default: done = 1'b1;
    endcase
    if (!done) begin
      r.nxt.partial = vlc[11:0];
      r.nxt.held    = held_n[1:0];
    end else begin
      r.emit        = 1'b1;
      r.nxt.partial = '0;
      r.nxt.held    = '0;
      len           = vlc[15:2];
      // zero length fills to the right edge
      if (len == '0) begin
        if (s.col > {1'b0, re}) len = 14'd1;
        else len = {3'b0, ({1'b0, re} - s.col + 11'd1)};
      end
      r.run.run_x      = s.col[9:0];
      r.run.run_y      = s.line;
      r.run.run_length = (len > LenMax) ? LenMax[9:0] : len[9:0];
      r.run.run_colour = vlc[1:0] & ColourMask;
      col_sum          = s.col + len[10:0];
      r.nxt.col        = col_sum;
      if (col_sum > {1'b0, re}) begin
        ny                = {1'b0, s.line} + 11'd2;
        r.run.line_end    = 1'b1;
        r.run.field_done  = (ny > {1'b0, be});
        r.nxt.col         = {1'b0, le};
        r.nxt.line        = ny[9:0];
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/srle_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srle channel interfaces
// Stream byte input, run output and configuration write channels.
// ----------------------------------------------------------------------------
interface srle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;
  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface srle_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] run_x;
  logic [9:0] run_y;
  logic [9:0] run_length;
  logic [1:0] run_colour;
  logic       line_end;
  logic       field_done;
  logic       last_of_byte;
  modport source (output valid, output run_x, output run_y, output run_length,
                  output run_colour, output line_end, output field_done,
                  output last_of_byte, input ready);
  modport sink   (input valid, input run_x, input run_y, input run_length,
                  input run_colour, input line_end, input field_done,
                  input last_of_byte, output ready);
endinterface

interface srle_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/subpicture_rle_field_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// subpicture_rle_field_decoder
// Decodes an interlaced field's run-length byte stream into runs.
// ----------------------------------------------------------------------------
// One stream byte is accepted per cycle. Both nibbles of the byte are decoded
// in the cycle it is accepted, and the zero, one or two runs it yields are
// written into a four-entry run queue; runs leave the queue one beat per
// cycle while the run sink is ready. The input is ready whenever at least
// two queue entries are free, so bytes go in at one per cycle as long as the
// run side keeps up; a stream where every byte yields two runs is held back
// by the single run output port. Configuration writes are taken every cycle.
module subpicture_rle_field_decoder
  import srle_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 720,
  parameter int SCREEN_HEIGHT = 576
) (
  input  wire logic  clk,
  input  wire logic  rst,
  srle_in_if.sink    stream,
  srle_out_if.source runs,
  srle_cfg_if.sink   cfg
);

  localparam logic [11:0] XLimit = 12'(SCREEN_WIDTH - 1);
  localparam logic [11:0] YLimit = 12'(SCREEN_HEIGHT - 1);
  localparam int          QDepth = 4;

  // configuration registers
  logic [9:0] left_edge, right_edge, top_edge, bottom_edge;
  logic       field_select;

  // decoder state
  dec_state_t state, state_next;
  logic       start_pending, start_pending_next;
  logic       field_finished, field_finished_next;

  // run queue
  run_t       q_mem [QDepth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;

  logic [9:0] le, re, te, be;
  dec_state_t base;
  step_t      s0, s1;
  logic       active, emit0, emit1, accept, pop;
  run_t       r0, r1, head;
  logic [1:0] n_runs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge    <= LeftEdgeReset;
      right_edge   <= RightEdgeReset;
      top_edge     <= TopEdgeReset;
      bottom_edge  <= BottomEdgeReset;
      field_select <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CfgLeftEdge:   left_edge    <= cfg.data;
        CfgRightEdge:  right_edge   <= cfg.data;
        CfgTopEdge:    top_edge     <= cfg.data;
        CfgBottomEdge: bottom_edge  <= cfg.data;
        CfgFieldSel:   field_select <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // edges saturated to the screen
  assign le = ({2'b0, left_edge}   > XLimit) ? XLimit[9:0] : left_edge;
  assign re = ({2'b0, right_edge}  > XLimit) ? XLimit[9:0] : right_edge;
  assign te = ({2'b0, top_edge}    > YLimit) ? YLimit[9:0] : top_edge;
  assign be = ({2'b0, bottom_edge} > YLimit) ? YLimit[9:0] : bottom_edge;

  always_comb begin
    base = state;
    if (start_pending) begin
      base.col  = {1'b0, le};
      base.line = te + {9'b0, field_select};
    end
  end

  assign s0 = nibble_step(base, stream.code_byte[7:4], le, re, be);
  assign s1 = nibble_step(s0.nxt, stream.code_byte[3:0], le, re, be);

  // a line end skips the rest of the byte
  assign active = !field_finished;
  assign emit0  = active && s0.emit;
  assign emit1  = active && !s0.run.line_end && s1.emit;
  assign n_runs = {1'b0, emit0} + {1'b0, emit1};

  always_comb begin
    r0              = s0.run;
    r0.last_of_byte = !emit1;
    r1              = s1.run;
    r1.last_of_byte = 1'b1;
  end

  always_comb begin
    state_next          = state;
    start_pending_next  = start_pending;
    field_finished_next = field_finished;
    if (active) begin
      start_pending_next = 1'b0;
      if (s0.run.line_end) begin
        state_next          = s0.nxt;
        field_finished_next = s0.run.field_done;
      end else begin
        state_next          = s1.nxt;
        field_finished_next = s1.run.field_done;
      end
    end
    if (stream.final_byte) begin
      state_next.partial  = '0;
      state_next.held     = '0;
      start_pending_next  = 1'b1;
      field_finished_next = 1'b0;
    end
  end

  assign stream.ready = (count <= 3'(QDepth - 2));
  assign accept       = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= '0;
      start_pending  <= 1'b1;
      field_finished <= 1'b0;
    end else if (accept) begin
      state          <= state_next;
      start_pending  <= start_pending_next;
      field_finished <= field_finished_next;
    end
  end

  assign head       = q_mem[rd_ptr];
  assign runs.valid = (count != '0);
  assign pop        = runs.valid && runs.ready;

  assign runs.run_x        = head.run_x;
  assign runs.run_y        = head.run_y;
  assign runs.run_length   = head.run_length;
  assign runs.run_colour   = head.run_colour;
  assign runs.line_end     = head.line_end;
  assign runs.field_done   = head.field_done;
  assign runs.last_of_byte = head.last_of_byte;

  always_comb begin
    count_next = count;
    if (accept) count_next = count_next + {1'b0, n_runs};
    if (pop) count_next = count_next - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (emit0) q_mem[wr_ptr] <= r0;
      if (emit1) q_mem[wr_ptr + {1'b0, emit0}] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + n_runs;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QDepth))
    else $error("run queue overfilled");

  a_finished_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && field_finished) |=> (count <= $past(count)))
    else $error("runs produced after field finished");

  a_pair_together: assert property (@(posedge clk) disable iff (rst)
    (runs.valid && !head.last_of_byte) |-> (count >= 3'd2))
    else $error("second run of a byte missing from queue");

  a_final_rearms: assert property (@(posedge clk) disable iff (rst)
    (accept && stream.final_byte) |=> (start_pending && !field_finished))
    else $error("final byte did not rearm start");
`endif

endmodule
`default_nettype wire
